/* hw/rtl/tsr_pkg.sv */
// Shared types and constants of the triangle span rasterizer.
`default_nettype none

package tsr_pkg;

    // Fixed field widths of the input and result items.
    localparam int VTX_W   = 16;
    localparam int COLOR_W = 32;
    localparam int OUT_W   = 10;

    // Edge vector components are differences of doubled vertex coordinates.
    localparam int EDGE_W  = VTX_W + 2;

    // The coverage unit issues its products edge by edge; ISSUE_LAST is the last issue slot.
    localparam int ISSUE_W = 3;
    localparam logic [ISSUE_W-1:0] ISSUE_LAST = 3'd5;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    // One accepted input item.
    typedef struct packed {
        logic                    kind;
        logic signed [VTX_W-1:0] x0;
        logic signed [VTX_W-1:0] y0;
        logic signed [VTX_W-1:0] x1;
        logic signed [VTX_W-1:0] y1;
        logic signed [VTX_W-1:0] x2;
        logic signed [VTX_W-1:0] y2;
        logic [COLOR_W-1:0]      color;
    } t_item;

    // Stored vertices of the active triangle.
    typedef struct packed {
        logic signed [VTX_W-1:0] x0;
        logic signed [VTX_W-1:0] y0;
        logic signed [VTX_W-1:0] x1;
        logic signed [VTX_W-1:0] y1;
        logic signed [VTX_W-1:0] x2;
        logic signed [VTX_W-1:0] y2;
    } t_tri;

    // One finished span.
    typedef struct packed {
        logic [OUT_W-1:0]   row;
        logic [OUT_W-1:0]   span_start;
        logic [OUT_W-1:0]   span_end;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_span;

endpackage

`default_nettype wire

/* hw/rtl/tsr_in_if.sv */
// Input channel of the triangle span rasterizer: valid, ready and one item.
`default_nettype none

interface tsr_in_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic signed [tsr_pkg::VTX_W-1:0] vertex0_x;
    logic signed [tsr_pkg::VTX_W-1:0] vertex0_y;
    logic signed [tsr_pkg::VTX_W-1:0] vertex1_x;
    logic signed [tsr_pkg::VTX_W-1:0] vertex1_y;
    logic signed [tsr_pkg::VTX_W-1:0] vertex2_x;
    logic signed [tsr_pkg::VTX_W-1:0] vertex2_y;
    logic [tsr_pkg::COLOR_W-1:0]      fill_rgba;

    modport source (
        output valid, kind, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
               vertex2_x, vertex2_y, fill_rgba,
        input  ready
    );

    modport sink (
        input  valid, kind, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
               vertex2_x, vertex2_y, fill_rgba,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/tsr_out_if.sv */
// Output channel of the triangle span rasterizer: valid, ready and one span.
`default_nettype none

interface tsr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsr_pkg::OUT_W-1:0]   row;
    logic [tsr_pkg::OUT_W-1:0]   span_start;
    logic [tsr_pkg::OUT_W-1:0]   span_end;
    logic [tsr_pkg::COLOR_W-1:0] span_color;
    logic                        last;

    modport source (
        output valid, row, span_start, span_end, span_color, last,
        input  ready
    );

    modport sink (
        input  valid, row, span_start, span_end, span_color, last,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/tsr_cover.sv */
// Shared multiply-accumulate unit that runs the inside test of a pixel against every edge of the triangle.
`default_nettype none

module tsr_cover #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int FRAC_BITS     = 4,
    localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1,
    localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [COL_W-1:0]   i_col,
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire tsr_pkg::t_tri      i_tri,
    output logic                    o_done,
    output logic                    o_inside
);

    // Doubled pixel center width, delta width, product and difference widths.
    localparam int CRD_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1 + FRAC_BITS;
    localparam int D_W   = ((CRD_W > tsr_pkg::VTX_W + 1) ? CRD_W : tsr_pkg::VTX_W + 1) + 2;
    localparam int E_W   = tsr_pkg::EDGE_W;
    localparam int P_W   = D_W + E_W;
    localparam int S_W   = P_W + 1;

    logic                        r_run;
    logic [tsr_pkg::ISSUE_W-1:0] r_issue;
    logic                        r_v1;
    logic                        r_v2;
    logic [tsr_pkg::ISSUE_W-1:0] r_t1;
    logic [tsr_pkg::ISSUE_W-1:0] r_t2;
    logic signed [D_W-1:0]       r_a;
    logic signed [E_W-1:0]       r_b;
    logic signed [P_W-1:0]       r_prod;
    logic signed [P_W-1:0]       r_acc;
    logic [1:0]                  r_pos;
    logic                        r_done;
    logic                        r_inside;

    logic signed [tsr_pkg::VTX_W-1:0] ax;
    logic signed [tsr_pkg::VTX_W-1:0] ay;
    logic signed [tsr_pkg::VTX_W-1:0] bx;
    logic signed [tsr_pkg::VTX_W-1:0] by;
    logic [CRD_W-1:0]                 px;
    logic [CRD_W-1:0]                 py;
    logic signed [D_W-1:0]            dx;
    logic signed [D_W-1:0]            dy;
    logic signed [E_W-1:0]            ex;
    logic signed [E_W-1:0]            ey;
    logic signed [D_W-1:0]            op_a;
    logic signed [E_W-1:0]            op_b;
    logic signed [S_W-1:0]            diff;
    logic                             pos_now;
    logic [2:0]                       pos_all;

    // Pick the directed edge of this issue slot: v0->v1, v1->v2, v2->v0.
    always_comb begin
        case (r_issue[2:1])
            2'd0: begin
                ax = i_tri.x0; ay = i_tri.y0; bx = i_tri.x1; by = i_tri.y1;
            end
            2'd1: begin
                ax = i_tri.x1; ay = i_tri.y1; bx = i_tri.x2; by = i_tri.y2;
            end
            default: begin
                ax = i_tri.x2; ay = i_tri.y2; bx = i_tri.x0; by = i_tri.y0;
            end
        endcase
    end

    // Operands in doubled units, so the pixel center lands on an integer.
    always_comb begin
        px   = CRD_W'({i_col, 1'b1}) << FRAC_BITS;
        py   = CRD_W'({i_row, 1'b1}) << FRAC_BITS;
        dx   = signed'(D_W'(px)) - D_W'(signed'({ax, 1'b0}));
        dy   = signed'(D_W'(py)) - D_W'(signed'({ay, 1'b0}));
        ex   = E_W'(signed'({bx, 1'b0})) - E_W'(signed'({ax, 1'b0}));
        ey   = E_W'(signed'({by, 1'b0})) - E_W'(signed'({ay, 1'b0}));
        op_a = r_issue[0] ? dy : dx;
        op_b = r_issue[0] ? ex : ey;
    end

    // Cross product sign of the edge that finishes in the accumulate stage.
    always_comb begin
        diff    = S_W'(r_acc) - S_W'(r_prod);
        pos_now = !diff[S_W-1] && (diff != '0);
        pos_all = {pos_now, r_pos};
    end

    // Issue counter and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_issue <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_start) begin
                r_run   <= 1'b1;
                r_issue <= '0;
            end else if (r_run) begin
                r_issue <= r_issue + tsr_pkg::ISSUE_W'(1);
                if (r_issue == tsr_pkg::ISSUE_LAST) begin
                    r_run <= 1'b0;
                end
            end
            r_v1   <= r_run;
            r_v2   <= r_v1;
            r_done <= r_v2 && (r_t2 == tsr_pkg::ISSUE_LAST);
        end
    end

    // Operand, product and accumulate stages.
    always_ff @(posedge i_clk) begin
        r_a    <= op_a;
        r_b    <= op_b;
        r_t1   <= r_issue;
        r_prod <= P_W'(r_a) * P_W'(r_b);
        r_t2   <= r_t1;
        if (r_v2) begin
            if (!r_t2[0]) begin
                r_acc <= r_prod;
            end else if (r_t2[2:1] == 2'd0) begin
                r_pos[0] <= pos_now;
            end else if (r_t2[2:1] == 2'd1) begin
                r_pos[1] <= pos_now;
            end else begin
                r_inside <= (&pos_all) || !(|pos_all);
            end
        end
    end

    assign o_done   = r_done;
    assign o_inside = r_inside;

endmodule

`default_nettype wire

/* hw/rtl/tsr_walk.sv */
// Triangle setup and the row sequencer that walks the left and right span edges.
`default_nettype none

module tsr_walk #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int FRAC_BITS     = 4,
    localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1,
    localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    input  wire tsr_pkg::t_item     i_item,
    output logic                    o_item_ready,
    output tsr_pkg::t_tri           o_tri,
    output logic                    o_probe_start,
    output logic [COL_W-1:0]        o_probe_col,
    output logic [ROW_W-1:0]        o_probe_row,
    input  wire logic               i_probe_done,
    input  wire logic               i_probe_inside,
    output logic                    o_span_valid,
    output tsr_pkg::t_span          o_span,
    input  wire logic               i_span_ready
);

    // The row limit is an exclusive end, so it may equal the screen height.
    localparam int LIM_W = $clog2(SCREEN_HEIGHT + 1);
    localparam int YW    = tsr_pkg::VTX_W;
    localparam int YW1   = tsr_pkg::VTX_W + 1;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [YW-1:0]    COL_MAX_V = YW'(SCREEN_WIDTH - 1);
    localparam logic [YW1-1:0]   ROUND_UP  = YW1'((1 << FRAC_BITS) - 1);
    localparam logic [YW1-1:0]   HEIGHT_V  = YW1'(SCREEN_HEIGHT);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SETUP     = 7'b0000010,
        S_LEFT_OUT  = 7'b0000100,
        S_LEFT_IN   = 7'b0001000,
        S_RIGHT_OUT = 7'b0010000,
        S_RIGHT_IN  = 7'b0100000,
        S_EMIT      = 7'b1000000
    } t_walk_state;

    t_walk_state                 r_state, n_state;
    tsr_pkg::t_tri               r_tri, n_tri;
    logic [tsr_pkg::COLOR_W-1:0] r_color, n_color;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [LIM_W-1:0]            r_limit, n_limit;
    logic [COL_W-1:0]            r_lo, n_lo;
    logic [COL_W-1:0]            r_hi, n_hi;
    logic                        r_active, n_active;
    logic                        r_wait, n_wait;

    logic signed [YW-1:0] y_first;
    logic signed [YW-1:0] x_first;
    logic signed [YW-1:0] y_top;
    logic signed [YW-1:0] x_top;
    logic signed [YW-1:0] y_max0;
    logic signed [YW-1:0] y_max1;
    logic signed [YW-1:0] y_max;
    logic [YW-1:0]        x_col;
    logic [COL_W-1:0]     setup_col;
    logic [YW-1:0]        start_row;
    logic [YW1-1:0]       end_incl;
    logic [YW1-1:0]       end_excl;
    logic [YW1-1:0]       end_row;
    logic                 has_rows;

    logic [COL_W-1:0] lo_dec;
    logic [COL_W-1:0] lo_inc;
    logic [COL_W-1:0] hi_inc;
    logic [COL_W-1:0] hi_dec;
    logic [LIM_W-1:0] row_nx;
    logic             fin;

    // Setup: top-most vertex (first on ties), lowest point, start column and rows.
    always_comb begin
        y_first   = (r_tri.y1 < r_tri.y0) ? r_tri.y1 : r_tri.y0;
        x_first   = (r_tri.y1 < r_tri.y0) ? r_tri.x1 : r_tri.x0;
        y_top     = (r_tri.y2 < y_first) ? r_tri.y2 : y_first;
        x_top     = (r_tri.y2 < y_first) ? r_tri.x2 : x_first;
        y_max0    = (r_tri.y0 > 0) ? r_tri.y0 : '0;
        y_max1    = (r_tri.y1 > y_max0) ? r_tri.y1 : y_max0;
        y_max     = (r_tri.y2 > y_max1) ? r_tri.y2 : y_max1;
        x_col     = unsigned'(x_top) >> FRAC_BITS;
        setup_col = x_top[YW-1] ? '0 :
                    ((x_col > COL_MAX_V) ? COL_LAST : COL_W'(x_col));
        start_row = y_top[YW-1] ? '0 : (unsigned'(y_top) >> FRAC_BITS);
        end_incl  = (YW1'(unsigned'(y_max)) + ROUND_UP) >> FRAC_BITS;
        end_excl  = end_incl + YW1'(1);
        end_row   = (end_excl > HEIGHT_V) ? HEIGHT_V : end_excl;
        has_rows  = YW1'(start_row) < end_row;
    end

    // Edge steps and the end-of-triangle check.
    always_comb begin
        lo_dec = r_lo - COL_W'(1);
        lo_inc = r_lo + COL_W'(1);
        hi_inc = r_hi + COL_W'(1);
        hi_dec = r_hi - COL_W'(1);
        row_nx = LIM_W'(r_row) + LIM_W'(1);
        fin    = row_nx >= r_limit;
    end

    // Sequencer: each walking phase probes one column at a time.
    always_comb begin
        n_state       = r_state;
        n_tri         = r_tri;
        n_color       = r_color;
        n_row         = r_row;
        n_limit       = r_limit;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_active      = r_active;
        n_wait        = r_wait;
        o_probe_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == tsr_pkg::KIND_LOAD) begin
                        n_tri.x0 = i_item.x0;
                        n_tri.y0 = i_item.y0;
                        n_tri.x1 = i_item.x1;
                        n_tri.y1 = i_item.y1;
                        n_tri.x2 = i_item.x2;
                        n_tri.y2 = i_item.y2;
                        n_color  = i_item.color;
                        n_state  = S_SETUP;
                    end else if (r_active) begin
                        n_wait  = 1'b0;
                        n_state = S_LEFT_OUT;
                    end
                end
            end
            S_SETUP: begin
                n_lo     = setup_col;
                n_hi     = setup_col;
                n_row    = ROW_W'(start_row);
                n_limit  = LIM_W'(end_row);
                n_active = has_rows;
                n_state  = S_IDLE;
            end
            S_LEFT_OUT: begin
                // Widen to the left while the column is covered.
                if (!r_wait) begin
                    if (r_lo != '0) begin
                        o_probe_start = 1'b1;
                        n_wait        = 1'b1;
                    end else begin
                        n_state = S_LEFT_IN;
                    end
                end else if (i_probe_done) begin
                    n_wait = 1'b0;
                    if (i_probe_inside) begin
                        n_lo = lo_dec;
                    end else begin
                        n_state = S_LEFT_IN;
                    end
                end
            end
            S_LEFT_IN: begin
                // Narrow from the left while the column is not covered.
                if (!r_wait) begin
                    if (r_lo != COL_LAST) begin
                        o_probe_start = 1'b1;
                        n_wait        = 1'b1;
                    end else begin
                        n_state = S_RIGHT_OUT;
                    end
                end else if (i_probe_done) begin
                    n_wait = 1'b0;
                    if (!i_probe_inside) begin
                        n_lo = lo_inc;
                        if (r_hi < lo_inc) begin
                            n_hi = lo_inc;
                        end
                    end else begin
                        n_state = S_RIGHT_OUT;
                    end
                end
            end
            S_RIGHT_OUT: begin
                // Widen to the right while the column is covered.
                if (!r_wait) begin
                    if (r_hi != COL_LAST) begin
                        o_probe_start = 1'b1;
                        n_wait        = 1'b1;
                    end else begin
                        n_state = S_RIGHT_IN;
                    end
                end else if (i_probe_done) begin
                    n_wait = 1'b0;
                    if (i_probe_inside) begin
                        n_hi = hi_inc;
                    end else begin
                        n_state = S_RIGHT_IN;
                    end
                end
            end
            S_RIGHT_IN: begin
                // Narrow from the right while the column is not covered.
                if (!r_wait) begin
                    if (r_hi != '0) begin
                        o_probe_start = 1'b1;
                        n_wait        = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (i_probe_done) begin
                    n_wait = 1'b0;
                    if (!i_probe_inside) begin
                        n_hi = hi_dec;
                        if (r_lo > hi_dec) begin
                            n_lo = hi_dec;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // Hand the span to the output register and move to the next row.
                if (i_span_ready) begin
                    n_row = ROW_W'(row_nx);
                    if (fin) begin
                        n_active = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_wait   <= n_wait;
        end
    end

    // Triangle and walk registers.
    always_ff @(posedge i_clk) begin
        r_tri   <= n_tri;
        r_color <= n_color;
        r_row   <= n_row;
        r_limit <= n_limit;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_tri        = r_tri;
    assign o_probe_col  = ((r_state == S_RIGHT_OUT) || (r_state == S_RIGHT_IN)) ? r_hi : r_lo;
    assign o_probe_row  = r_row;

    assign o_span_valid      = (r_state == S_EMIT);
    assign o_span.row        = tsr_pkg::OUT_W'(r_row);
    assign o_span.span_start = tsr_pkg::OUT_W'(r_lo);
    assign o_span.span_end   = tsr_pkg::OUT_W'(r_hi);
    assign o_span.color      = r_color;
    assign o_span.last       = fin;

endmodule

`default_nettype wire

/* hw/rtl/triangle_span_rasterizer_top.sv */
// Top level of the triangle span rasterizer: handshakes, output register and the two units.
//
//  channel  | dir | transfer carries                          | width
//  ---------+-----+-------------------------------------------+------
//  i_in     | in  | kind, three vertices (x, y), fill_rgba    | 129
//  o_out    | out | row, span_start, span_end, span_color, last | 63
//
// A load item (kind 0) is captured in the idle state, then goes through triangle setup.
// A row item probes its columns one at a time; each probe runs all of its
// products through the one shared multiplier, and an interior row probes at least four times.
// A row item with no active triangle is taken and gives no span.
// Reset is synchronous and active low; it leaves no triangle active.
// A finished span waits in the output register; the next stalls while o_out.ready is low.
`default_nettype none

module triangle_span_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int FRAC_BITS     = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tsr_in_if.sink        i_in,
    tsr_out_if.source     o_out
);

    localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    tsr_pkg::t_item   item;
    logic             item_ready;
    tsr_pkg::t_tri    tri_v;
    logic             probe_start;
    logic [COL_W-1:0] probe_col;
    logic [ROW_W-1:0] probe_row;
    logic             probe_done;
    logic             probe_inside;
    logic             span_valid;
    tsr_pkg::t_span   span;
    logic             span_ready;

    logic             r_out_valid;
    tsr_pkg::t_span   r_out;

    // Gather the input transfer into one item.
    always_comb begin
        item.kind  = i_in.kind;
        item.x0    = i_in.vertex0_x;
        item.y0    = i_in.vertex0_y;
        item.x1    = i_in.vertex1_x;
        item.y1    = i_in.vertex1_y;
        item.x2    = i_in.vertex2_x;
        item.y2    = i_in.vertex2_y;
        item.color = i_in.fill_rgba;
    end

    assign i_in.ready = item_ready;

    tsr_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_in.valid),
        .i_item         (item),
        .o_item_ready   (item_ready),
        .o_tri          (tri_v),
        .o_probe_start  (probe_start),
        .o_probe_col    (probe_col),
        .o_probe_row    (probe_row),
        .i_probe_done   (probe_done),
        .i_probe_inside (probe_inside),
        .o_span_valid   (span_valid),
        .o_span         (span),
        .i_span_ready   (span_ready)
    );

    tsr_cover #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_cover (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (probe_start),
        .i_col    (probe_col),
        .i_row    (probe_row),
        .i_tri    (tri_v),
        .o_done   (probe_done),
        .o_inside (probe_inside)
    );

    // The output register takes a new span when it is empty or being emptied.
    assign span_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (span_valid && span_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (span_valid && span_ready) begin
            r_out <= span;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.row        = r_out.row;
    assign o_out.span_start = r_out.span_start;
    assign o_out.span_end   = r_out.span_end;
    assign o_out.span_color = r_out.color;
    assign o_out.last       = r_out.last;

endmodule

`default_nettype wire

/* hw/rtl/tsr_checker.sv */
// Port-level checks of the triangle span rasterizer and their binding to the top level.
`default_nettype none

module tsr_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_in_kind,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [tsr_pkg::OUT_W-1:0] i_span_start,
    input wire logic [tsr_pkg::OUT_W-1:0] i_span_end
);

    // A span that is offered stays offered until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("span withdrawn before its transfer");

    // Every span covers at least one pixel.
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_span_start <= i_span_end))
        else $error("span start lies right of span end");

    // Setup follows a load, so the input is closed in the next cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == tsr_pkg::KIND_LOAD) |=> !i_in_ready)
        else $error("input open right after a triangle load");

    // A new span only appears after the input was closed for the row walk.
    a_span_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("span appeared without a row walk");

endmodule

bind triangle_span_rasterizer_top tsr_checker u_tsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_kind    (i_in.kind),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_span_start (o_out.span_start),
    .i_span_end   (o_out.span_end)
);

`default_nettype wire

/* tb/tb_triangle_span_rasterizer_top.sv */
// Self-checking testbench of the triangle span rasterizer: span predictor, stimulus and checks.
`timescale 1ns / 100ps

// Predicts the spans of the rasterizer and compares the ones that leave the block.
class t_span_scoreboard;
    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 600;
    localparam int FRAC     = 4;

    logic signed [tsr_pkg::VTX_W-1:0] vx[3];
    logic signed [tsr_pkg::VTX_W-1:0] vy[3];
    logic [tsr_pkg::COLOR_W-1:0]      fill;
    logic [10:0]                      cur_row;
    logic [19:0]                      row_limit;
    logic [tsr_pkg::OUT_W-1:0]        left_col;
    logic [tsr_pkg::OUT_W-1:0]        right_col;
    bit                               active;
    tsr_pkg::t_span                   pending[$];
    int                               n_errors;
    int                               n_checked;

    function new();
        int i;
        for (i = 0; i < 3; i++) begin
            vx[i] = '0;
            vy[i] = '0;
        end
        fill      = '0;
        cur_row   = '0;
        row_limit = '0;
        left_col  = '0;
        right_col = '0;
        active    = 1'b0;
        n_errors  = 0;
        n_checked = 0;
    endfunction

    // First row of a triangle: the top vertex y in pixels, never above row 0.
    static function int first_row(tsr_pkg::t_item it);
        int ymin;
        ymin = $signed(it.y0);
        if ($signed(it.y1) < ymin) ymin = $signed(it.y1);
        if ($signed(it.y2) < ymin) ymin = $signed(it.y2);
        return (ymin < 0) ? 0 : (ymin >> FRAC);
    endfunction

    // Exclusive end row: one past the rounded-up lowest vertex, clipped to the screen.
    static function int row_end(tsr_pkg::t_item it);
        int ymax;
        int e;
        ymax = 0;
        if ($signed(it.y0) > ymax) ymax = $signed(it.y0);
        if ($signed(it.y1) > ymax) ymax = $signed(it.y1);
        if ($signed(it.y2) > ymax) ymax = $signed(it.y2);
        e = ((ymax + (1 << FRAC) - 1) >> FRAC) + 1;
        return (e > SCREEN_H) ? SCREEN_H : e;
    endfunction

    // Number of spans a load item makes available.
    static function int rows_of(tsr_pkg::t_item it);
        int n;
        n = row_end(it) - first_row(it);
        return (n > 0) ? n : 0;
    endfunction

    // Pixel center test against all three directed edges, in doubled coordinates.
    function bit covered(int col, int row);
        longint px, py;
        longint ax[3], ay[3];
        bit     pos[3];
        int     i, b;
        px = longint'(2 * col + 1) <<< FRAC;
        py = longint'(2 * row + 1) <<< FRAC;
        for (i = 0; i < 3; i++) begin
            ax[i] = 2 * longint'(vx[i]);
            ay[i] = 2 * longint'(vy[i]);
        end
        for (i = 0; i < 3; i++) begin
            b = (i + 1) % 3;
            pos[i] = (px - ax[i]) * (ay[b] - ay[i]) - (py - ay[i]) * (ax[b] - ax[i]) > 0;
        end
        return (pos[0] && pos[1] && pos[2]) || !(pos[0] || pos[1] || pos[2]);
    endfunction

    // Updates the predicted state for one accepted item and queues any span it causes.
    function void note_item(tsr_pkg::t_item it);
        tsr_pkg::t_span want;
        int             top, tx, y, lo, hi;
        if (it.kind == tsr_pkg::KIND_LOAD) begin
            vx[0] = it.x0;  vy[0] = it.y0;
            vx[1] = it.x1;  vy[1] = it.y1;
            vx[2] = it.x2;  vy[2] = it.y2;
            fill  = it.color;
            // On a tie the earliest vertex stays on top.
            top = 0;
            if (vy[1] < vy[top]) top = 1;
            if (vy[2] < vy[top]) top = 2;
            tx = vx[top];
            if (tx < 0) left_col = '0;
            else if ((tx >> FRAC) > SCREEN_W - 1) left_col = tsr_pkg::OUT_W'(SCREEN_W - 1);
            else left_col = tsr_pkg::OUT_W'(tx >> FRAC);
            right_col = left_col;
            cur_row   = 11'(first_row(it));
            row_limit = 20'(row_end(it));
            active    = 20'(cur_row) < row_limit;
            return;
        end
        if (!active) return;

        // Walk both edges: widen while inside, narrow while outside.
        y  = int'(cur_row);
        lo = int'(left_col);
        hi = int'(right_col);
        while (lo > 0 && covered(lo, y)) lo--;
        while (lo < SCREEN_W - 1 && !covered(lo, y)) begin
            lo++;
            if (hi < lo) hi = lo;
        end
        while (hi < SCREEN_W - 1 && covered(hi, y)) hi++;
        while (hi > 0 && !covered(hi, y)) begin
            hi--;
            if (lo > hi) lo = hi;
        end
        left_col  = tsr_pkg::OUT_W'(lo);
        right_col = tsr_pkg::OUT_W'(hi);

        want.row        = y[tsr_pkg::OUT_W-1:0];
        want.span_start = lo[tsr_pkg::OUT_W-1:0];
        want.span_end   = hi[tsr_pkg::OUT_W-1:0];
        want.color      = fill;
        want.last       = (y + 1) >= int'(row_limit);
        pending.push_back(want);
        cur_row = 11'(y + 1);
        if (want.last) active = 1'b0;
    endfunction

    // Compares one span taken from the block with the oldest prediction.
    function void check_span(tsr_pkg::t_span got);
        tsr_pkg::t_span want;
        if (pending.size() == 0) begin
            n_errors++;
            $error("span with no prediction: row %0d, start %0d, end %0d",
                   got.row, got.span_start, got.span_end);
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.row != want.row) begin
            n_errors++;
            $error("row: expected %0d, actual %0d", want.row, got.row);
        end
        if (got.span_start != want.span_start) begin
            n_errors++;
            $error("span_start: expected %0d, actual %0d", want.span_start, got.span_start);
        end
        if (got.span_end != want.span_end) begin
            n_errors++;
            $error("span_end: expected %0d, actual %0d", want.span_end, got.span_end);
        end
        if (got.color != want.color) begin
            n_errors++;
            $error("span_color: expected %08h, actual %08h", want.color, got.color);
        end
        if (got.last != want.last) begin
            n_errors++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
        end
    endfunction
endclass

module tb_triangle_span_rasterizer_top;

    localparam int CLK_PERIOD = 12;
    localparam int ITEM_GOAL  = 950;
    localparam int LONG_HOLD  = 3000;
    // Worst row walk is about 1600 probes; the limit covers about 950 items at that cost,
    // plus gaps and stalls.
    localparam int LIMIT_CYCLES = 80_000_000;

    typedef enum {RX_ALWAYS, RX_COIN, RX_PULSE, RX_SPARSE} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tsr_in_if  in_ch ();
    tsr_out_if out_ch ();

    t_span_scoreboard sb = new();
    int               burst_left  = 0;
    int               cycle_count = 0;

    triangle_span_rasterizer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit in case the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output monitor: every span transfer is checked at the clock edge that takes it.
    always @(posedge i_clk) begin
        tsr_pkg::t_span got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.row        = out_ch.row;
            got.span_start = out_ch.span_start;
            got.span_end   = out_ch.span_end;
            got.color      = out_ch.span_color;
            got.last       = out_ch.last;
            sb.check_span(got);
        end
    end

    function automatic tsr_pkg::t_item load_item(int x0, int y0, int x1, int y1, int x2,
                                                 int y2, logic [tsr_pkg::COLOR_W-1:0] color);
        tsr_pkg::t_item it;
        it.kind  = tsr_pkg::KIND_LOAD;
        it.x0    = tsr_pkg::VTX_W'(x0);
        it.y0    = tsr_pkg::VTX_W'(y0);
        it.x1    = tsr_pkg::VTX_W'(x1);
        it.y1    = tsr_pkg::VTX_W'(y1);
        it.x2    = tsr_pkg::VTX_W'(x2);
        it.y2    = tsr_pkg::VTX_W'(y2);
        it.color = color;
        return it;
    endfunction

    // Row requests carry random payload that the block must ignore.
    function automatic tsr_pkg::t_item row_item();
        tsr_pkg::t_item it;
        it      = load_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
        it.kind = tsr_pkg::KIND_ROW;
        return it;
    endfunction

    // Compact triangle around a random point near the screen, in sixteenths.
    function automatic tsr_pkg::t_item small_triangle();
        int cx, cy, r, i;
        int c[6];
        cx = ($urandom_range(0, 840) - 20) * 16;
        cy = ($urandom_range(0, 620) - 10) * 16;
        r  = $urandom_range(2, 14) * 16;
        for (i = 0; i < 6; i++)
            c[i] = ((i % 2) ? cy : cx) + $urandom_range(0, 2 * r) - r;
        return load_item(c[0], c[1], c[2], c[3], c[4], c[5], $urandom);
    endfunction

    // Zero-area triangle: three coincident points, or three points on one line.
    function automatic tsr_pkg::t_item flat_triangle(bit coincident);
        int px, py, dx, dy, k1, k2;
        px = $urandom_range(0, 12800);
        py = $urandom_range(0, 9600);
        dx = coincident ? 0 : $urandom_range(0, 80) - 40;
        dy = coincident ? 0 : $urandom_range(0, 80) - 40;
        k1 = $urandom_range(1, 4);
        k2 = $urandom_range(1, 4);
        return load_item(px, py, px + dx * k1, py + dy * k1, px + dx * k2, py + dy * k2,
                         $urandom);
    endfunction

    // Offers one item in bursts separated by random gaps, and waits for its transfer.
    task automatic send_item(tsr_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.kind      = it.kind;
        in_ch.vertex0_x = it.x0;
        in_ch.vertex0_y = it.y0;
        in_ch.vertex1_x = it.x1;
        in_ch.vertex1_y = it.y1;
        in_ch.vertex2_x = it.x2;
        in_ch.vertex2_y = it.y2;
        in_ch.fill_rgba = it.color;
        in_ch.valid     = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    task automatic run_triangle(tsr_pkg::t_item ld, int n_rows);
        send_item(ld);
        repeat (n_rows) send_item(row_item());
    endtask

    // Sink side: ready follows changing stall patterns, with two long hold-offs
    // that let the block fill up and back-pressure its input.
    initial begin
        t_rx_mode mode;
        int       run, phase, holds_done;
        phase      = 0;
        holds_done = 0;
        out_ch.ready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            run  = $urandom_range(8, 160);
            repeat (run) begin
                @(negedge i_clk);
                if (holds_done < 2 && sb.n_checked >= 60 + 240 * holds_done) begin
                    out_ch.ready = 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    holds_done++;
                end
                phase++;
                case (mode)
                    RX_ALWAYS: out_ch.ready = 1'b1;
                    RX_COIN:   out_ch.ready = ($urandom_range(0, 1) == 1);
                    RX_PULSE:  out_ch.ready = (phase % 5) < 3;
                    default:   out_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Reset, directed triangles, random triangles, then drain.
    initial begin
        tsr_pkg::t_item ld;
        int             pick, avail, n, counted;
        in_ch.valid     = 1'b0;
        in_ch.kind      = tsr_pkg::KIND_LOAD;
        in_ch.vertex0_x = '0;
        in_ch.vertex0_y = '0;
        in_ch.vertex1_x = '0;
        in_ch.vertex1_y = '0;
        in_ch.vertex2_x = '0;
        in_ch.vertex2_y = '0;
        in_ch.fill_rgba = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A row request with no triangle loaded is dropped.
        send_item(row_item());
        // Ordinary small triangle, every row including the final one.
        ld = load_item(1605, 803, 1700, 860, 1540, 850, 32'hFFFF_FFFF);
        run_triangle(ld, sb.rows_of(ld));
        // Extreme coordinates, start column clamped at the left border.
        run_triangle(load_item(-32768, -32768, 32767, 32767, -32768, 32767, 32'h0), 2);
        // Two vertices share the top y; loading abandons the triangle still active.
        run_triangle(load_item(4000, 1100, 3800, 1000, 4300, 1000, 32'h1234_5678), 3);
        // All vertices coincide, so every pixel counts as inside.
        ld = load_item(3200, 1600, 3200, 1600, 3200, 1600, 32'hA5A5_A5A5);
        run_triangle(ld, sb.rows_of(ld));
        // Wholly above the screen: still one span on row 0, at minimum width.
        run_triangle(load_item(-32768, -32768, 32767, -32768, 0, -100, 32'h8000_0001), 1);
        // Wholly below the screen: no rows, the row request is dropped.
        run_triangle(load_item(100, 9600, 200, 32767, 300, 20000, 32'h7FFF_FFFE), 1);
        // Start column clamped at the right border.
        run_triangle(load_item(32767, 160, 32000, 300, 32767, 300, 32'h0F0F_0F0F), 2);

        // Random part: mostly compact triangles, some run to completion.
        counted = 0;
        while (counted < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95) begin
                send_item(row_item());
            end else begin
                if (pick < 75) ld = small_triangle();
                else if (pick < 88) ld = load_item($urandom, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom);
                else ld = flat_triangle($urandom_range(0, 1));
                avail = sb.rows_of(ld);
                if (pick >= 75 && ld.x0 != ld.x1)
                    n = (avail < 2) ? avail : $urandom_range(0, 2);
                else if ($urandom_range(0, 2) == 0)
                    n = avail + $urandom_range(0, 1);
                else
                    n = (avail == 0) ? 0 : $urandom_range(0, avail - 1);
                run_triangle(ld, n);
                counted += 1 + ((n < avail) ? n : avail);
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        // Drain, then allow a short tail for any span that should not exist.
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
